// File: rtl/core/circular_deque_top_defines.svh
// Assertion macros shared by the deque checker.
// No dependencies; take in by `include before use.
`ifndef CIRCULAR_DEQUE_TOP_DEFINES_SVH
`define CIRCULAR_DEQUE_TOP_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque checker: same-cycle rule violated");

// Next-cycle implication, quiet while reset is asserted.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque checker: next-cycle rule violated");

`endif

// File: rtl/core/cdq_pkg.sv
// Package for the circular deque: beat types, action and status codes.
// No dependencies.
package cdq_pkg;

    localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [2:0] ACT_POP_BACK   = 3'd2;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [2:0] ACT_READ       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
        logic [4:0]         position;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [5:0]         count;
        logic               is_empty;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic shift_in;   // push front: take the word from the front-side neighbour
        logic shift_out;  // pop front: take the word from the back-side neighbour
        logic load_back;  // push back: the selected cell takes the pushed value
    } cell_ctl_t;

endpackage

// File: rtl/core/cdq_cell.sv
// One storage cell of the deque row; holds the element at a fixed logical slot.
// Depends on cdq_pkg.
module cdq_cell (
    input  logic                clk,
    input  cdq_pkg::cell_ctl_t  ctl,
    input  logic                back_sel,
    input  logic signed [31:0]  fill,
    input  logic signed [31:0]  prev_data,
    input  logic signed [31:0]  next_data,
    output logic signed [31:0]  data
);
    import cdq_pkg::*;

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_in)
        begin
            data_next = prev_data;
        end
        else if (ctl.shift_out)
        begin
            data_next = next_data;
        end
        else if (ctl.load_back && back_sel)
        begin
            data_next = fill;
        end
    end

    // payload only: no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/core/circular_deque_top.sv
// Top level of the circular deque: a row of cdq_cell instances plus count and result register.
// Depends on cdq_pkg and cdq_cell.
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+------------------------------------
//  req     | in        | req_valid/req_stall | action, value, position (req_t)
//  rsp     | out       | rsp_valid/rsp_stall | read_data, count, is_empty, status
//
// One request beat per cycle while req_stall is low; its response appears in the
// result register in the cycle after acceptance.
// Reset clears the element count and the result valid flag; cell contents stay
// undefined until pushed and are never shown before they are written.
// req_stall rises only while a response waits and rsp_stall holds it, so a
// request is still taken in the same cycle the waiting response drains.
module circular_deque_top #(
    parameter int CAPACITY = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  cdq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cdq_pkg::rsp_t rsp
);
    import cdq_pkg::*;

    // count range 0..CAPACITY
    localparam int CW   = $clog2(CAPACITY + 1);
    // compare width for position against count
    localparam int CMPW = (CW > 5) ? CW : 5;
    // width used when taking the low six bits of the count
    localparam int CNTW = (CW > 6) ? CW : 6;
    // a read can only reach the first 32 slots (five-bit position)
    localparam int NR   = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int IW   = $clog2(NR);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic               accept;
    logic               full;
    logic               empty;
    cell_ctl_t          ctl;
    cell_ctl_t          cell_ctl;
    logic [1:0]         status;
    logic signed [31:0] rdata;
    logic signed [31:0] rd_word;
    logic [CNTW-1:0]    count_wide;

    logic signed [31:0] cell_q [CAPACITY];
    logic signed [31:0] rd_view [NR];

    // hold the request while a finished response waits on a stalled sink
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);

    assign rd_word = rd_view[req.position[IW-1:0]];

    // decode the action against the current count
    always_comb
    begin
        ctl        = '0;
        count_next = count_reg;
        status     = ST_OK;
        rdata      = '0;
        case (req.action)
            ACT_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctl.load_back = 1'b1;
                    count_next    = count_reg + CW'(1);
                end
            end
            ACT_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctl.shift_in = 1'b1;
                    count_next   = count_reg + CW'(1);
                end
            end
            ACT_POP_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    // drop the back element: only the count moves
                    count_next = count_reg - CW'(1);
                end
            end
            ACT_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    ctl.shift_out = 1'b1;
                    count_next    = count_reg - CW'(1);
                end
            end
            ACT_READ:
            begin
                if (CMPW'(req.position) >= CMPW'(count_reg))
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    rdata = rd_word;
                end
            end
            default:
            begin
                // unused codes leave the deque untouched
            end
        endcase
    end

    // advance the cells only on an accepted beat
    assign cell_ctl = accept ? ctl : '0;

    // cell 0 takes the pushed value on push front; the last cell holds on pop front
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [31:0] prev_w;
            logic signed [31:0] next_w;

            if (gi == 0)
            begin : g_first
                assign prev_w = req.value;
            end
            else
            begin : g_mid_prev
                assign prev_w = cell_q[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_w = cell_q[gi];
            end
            else
            begin : g_mid_next
                assign next_w = cell_q[gi+1];
            end

            cdq_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl),
                .back_sel  (count_reg == CW'(gi)),
                .fill      (req.value),
                .prev_data (prev_w),
                .next_data (next_w),
                .data      (cell_q[gi])
            );
        end

        for (gi = 0; gi < NR; gi++)
        begin : g_rd
            assign rd_view[gi] = cell_q[gi];
        end
    endgenerate

    assign count_wide = CNTW'(count_next);

    always_comb
    begin
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg;
        if (accept)
        begin
            rsp_next.read_data = rdata;
            rsp_next.count     = count_wide[5:0];
            rsp_next.is_empty  = (count_next == '0);
            rsp_next.status    = status;
            rsp_valid_next     = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload: no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/core/cdq_checker.sv
// Port-level checker for circular_deque_top, bound to every instance.
// Depends on cdq_pkg and circular_deque_top_defines.svh.
`include "circular_deque_top_defines.svh"

module cdq_checker #(
    parameter int CAPACITY = 32
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input cdq_pkg::rsp_t rsp
);
    import cdq_pkg::*;

    // a stalled response beat holds
    `CDQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // every accepted request yields a response beat in the next cycle
    `CDQ_ASSERT_NEXT(a_req_to_rsp, clk, rst_n, req_valid && !req_stall, rsp_valid)

    // a refused push reports a full deque
    `CDQ_ASSERT_NOW(a_full_count, clk, rst_n, rsp_valid && (rsp.status == ST_FULL), rsp.count == 6'(CAPACITY))

    // a refused pop reports an empty deque
    `CDQ_ASSERT_NOW(a_empty_flag, clk, rst_n, rsp_valid && (rsp.status == ST_EMPTY), rsp.is_empty && (rsp.count == '0))

    // read data is zero unless the beat succeeded
    `CDQ_ASSERT_NOW(a_zero_data, clk, rst_n, rsp_valid && (rsp.status != ST_OK), rsp.read_data == '0)

endmodule

bind circular_deque_top cdq_checker #(.CAPACITY(CAPACITY)) u_cdq_checker (.*);

// File: dv/circular_deque_checker.sv
// Checker for circular_deque_top: keeps its own ring deque, predicts each response
// beat and compares it field by field. Depends on cdq_pkg.
module circular_deque_checker #(
    parameter int CAPACITY = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  cdq_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  cdq_pkg::rsp_t rsp,
    output int            mismatches,
    output int            pending,
    output int            results_checked,
    output int            full_seen,
    output int            empty_seen,
    output int            range_seen
);
    import cdq_pkg::*;

    logic signed [31:0] ring [CAPACITY];
    int                 front_slot = 0;
    int                 held = 0;
    rsp_t               awaited_rsps [$];

    initial
    begin
        mismatches      = 0;
        pending         = 0;
        results_checked = 0;
        full_seen       = 0;
        empty_seen      = 0;
        range_seen      = 0;
    end

    // Apply one request to the shadow deque and return the response it should give.
    function automatic rsp_t apply_action(input req_t b);
        rsp_t r;
        r        = '0;
        r.status = ST_OK;
        case (b.action)
            ACT_PUSH_BACK:
                if (held >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    ring[(front_slot + held) % CAPACITY] = b.value;
                    held++;
                end
            ACT_PUSH_FRONT:
                if (held >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    front_slot       = (front_slot + CAPACITY - 1) % CAPACITY;
                    ring[front_slot] = b.value;
                    held++;
                end
            ACT_POP_BACK:
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                    held--;
            ACT_POP_FRONT:
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    front_slot = (front_slot + 1) % CAPACITY;
                    held--;
                end
            ACT_READ:
                if (int'(b.position) >= held)
                    r.status = ST_RANGE;
                else
                    r.read_data = ring[(front_slot + int'(b.position)) % CAPACITY];
            default:
                ;
        endcase
        r.count    = 6'(held);
        r.is_empty = (held == 0);
        return r;
    endfunction

    // The response taken at an edge always belongs to an earlier request, so
    // check it first, then predict the request taken at the same edge.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response beat with none awaited: data %0d count %0d",
                                 $realtime, rsp.read_data, rsp.count);
                end
                else
                begin
                    want = awaited_rsps[0];
                    awaited_rsps.delete(0);
                    results_checked++;
                    case (want.status)
                        ST_FULL:  full_seen++;
                        ST_EMPTY: empty_seen++;
                        ST_RANGE: range_seen++;
                        default:  ;
                    endcase
                    if (rsp.read_data !== want.read_data || rsp.count !== want.count ||
                        rsp.is_empty !== want.is_empty || rsp.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: response mismatch: expected data %0d count %0d ",
                                      "empty %0b status %0d, got data %0d count %0d ",
                                      "empty %0b status %0d"},
                                     $realtime, want.read_data, want.count, want.is_empty,
                                     want.status, rsp.read_data, rsp.count, rsp.is_empty,
                                     rsp.status);
                    end
                end
            end
            if (req_valid && !req_stall)
                awaited_rsps.insert(awaited_rsps.size(), apply_action(req));
            pending = awaited_rsps.size();
        end
    end

endmodule

// File: dv/circular_deque_top_tb.sv
// Testbench top for circular_deque_top: drives request beats and response stalls,
// and gives the verdict. Depends on cdq_pkg, circular_deque_top and circular_deque_checker.
module circular_deque_top_tb;

    import cdq_pkg::*;

    localparam int ITEM_TARGET = 850;
    localparam int PHASES      = 5;

    // Random request mix: lean towards filling, towards draining, or balanced,
    // so that the deque swings between empty and full many times.
    typedef enum logic [1:0] {FILLING, DRAINING, MIXED} drift_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;

    int mismatches;
    int pending;
    int results_checked;
    int full_seen;
    int empty_seen;
    int range_seen;

    always #10 clk = ~clk;

    circular_deque_top #(
        .CAPACITY(32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    circular_deque_checker #(
        .CAPACITY(32)
    ) checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .full_seen       (full_seen),
        .empty_seen      (empty_seen),
        .range_seen      (range_seen)
    );

    // Receiver side: decide the stall for the coming edge at each falling edge.
    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // Build one request beat.
    function automatic req_t make_beat(input logic [2:0] act, input logic signed [31:0] val,
                                       input logic [4:0] pos);
        req_t b;
        b.action   = act;
        b.value    = val;
        b.position = pos;
        return b;
    endfunction

    // Draw a random request beat under the given drift. A few beats carry an
    // unused action code and are simply ignored by the block.
    function automatic req_t random_beat(input drift_t drift);
        req_t b;
        int   pick;
        int   push_pct;
        int   pop_pct;
        int   read_pct;
        case (drift)
            FILLING:  begin push_pct = 75; pop_pct = 5;  read_pct = 15; end
            DRAINING: begin push_pct = 5;  pop_pct = 75; read_pct = 15; end
            default:  begin push_pct = 35; pop_pct = 35; read_pct = 25; end
        endcase
        b.value = $urandom;
        case ($urandom_range(15))
            0:       b.value = 32'sh7FFF_FFFF;
            1:       b.value = 32'sh8000_0000;
            2:       b.value = '0;
            3:       b.value = '1;
            default: ;
        endcase
        // Bias towards low positions so that many reads land inside the held range.
        b.position = $urandom_range(1) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < push_pct)
            b.action = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        else if (pick < push_pct + pop_pct)
            b.action = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
        else if (pick < push_pct + pop_pct + read_pct)
            b.action = ACT_READ;
        else
            b.action = ACT_READ + 3'($urandom_range(1, 3));
        return b;
    endfunction

    // Send one beat. Entered just after a falling edge; returns just after the
    // falling edge that follows acceptance, so back-to-back beats keep valid high
    // with a single assignment per step.
    task automatic send_beat(input req_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= b;
        // Hold the beat until an edge sees it with no stall.
        do
            @(posedge clk);
        while (req_stall);
        items_sent++;
        @(negedge clk);
    endtask

    // Pause the sender until every awaited response has been checked.
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int     counted;
        int     segment_left;
        drift_t drift;
        req_t   b;

        // Hold reset, then release it on a falling edge.
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening: empty-deque errors, extreme values at both ends,
        // wrap of the front below slot zero, reads in and beyond range, unused
        // codes, then pops back down to empty and past it.
        send_beat(make_beat(ACT_READ,       '0,            5'd0));
        send_beat(make_beat(ACT_READ,       '0,            5'd31));
        send_beat(make_beat(ACT_POP_BACK,   '0,            5'd0));
        send_beat(make_beat(ACT_POP_FRONT,  '0,            5'd0));
        send_beat(make_beat(ACT_PUSH_BACK,  32'sh7FFF_FFFF, 5'd0));
        send_beat(make_beat(ACT_PUSH_FRONT, 32'sh8000_0000, 5'd31));
        send_beat(make_beat(ACT_PUSH_BACK,  '1,            5'd0));
        send_beat(make_beat(ACT_PUSH_FRONT, '0,            5'd0));
        send_beat(make_beat(ACT_READ,       '1,            5'd0));
        send_beat(make_beat(ACT_READ,       '0,            5'd1));
        send_beat(make_beat(ACT_READ,       '0,            5'd2));
        send_beat(make_beat(ACT_READ,       '0,            5'd3));
        send_beat(make_beat(ACT_READ,       '0,            5'd4));
        send_beat(make_beat(ACT_READ,       '0,            5'd31));
        send_beat(make_beat(ACT_READ + 3'd1, 32'sh1234_5678, 5'd1));
        send_beat(make_beat(ACT_READ + 3'd2, '1,           5'd31));
        send_beat(make_beat(ACT_READ + 3'd3, 32'sh8000_0000, 5'd0));
        send_beat(make_beat(ACT_POP_FRONT,  '0,            5'd0));
        send_beat(make_beat(ACT_POP_BACK,   '0,            5'd0));
        send_beat(make_beat(ACT_READ,       '0,            5'd1));
        send_beat(make_beat(ACT_POP_BACK,   '0,            5'd0));
        send_beat(make_beat(ACT_POP_FRONT,  '0,            5'd0));
        send_beat(make_beat(ACT_POP_FRONT,  '0,            5'd0));
        send_beat(make_beat(ACT_READ,       '0,            5'd0));
        drain_responses();

        // Random part in phases of idling: none, sender mostly idle, receiver
        // mostly stalling, both now and then, and a last stretch with none.
        // Every beat, unused codes included, counts towards the item target.
        counted      = 0;
        segment_left = 0;
        drift        = FILLING;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1:       begin send_idle_pct = 88; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 88; end
                3:       begin send_idle_pct = 29; stall_pct = 29; end
                default: begin send_idle_pct = 0;  stall_pct = 0;  end
            endcase
            while (counted < (ITEM_TARGET * (phase + 1)) / PHASES)
            begin
                if (segment_left == 0)
                begin
                    segment_left = $urandom_range(50, 90);
                    drift        = drift_t'($urandom_range(2));
                end
                segment_left--;
                b = random_beat(drift);
                send_beat(b);
                counted++;
            end
            // Let every awaited response arrive before the idling changes.
            drain_responses();
        end

        // Let any stray response show before the verdict, with stalls off.
        stall_pct = 0;
        repeat (4) @(negedge clk);

        $display("checked %0d responses for %0d request beats", results_checked, items_sent);
        $display("refused pushes %0d, empty pops %0d, out-of-range reads %0d",
                 full_seen, empty_seen, range_seen);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #(20 * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: circular_deque_top.f
+incdir+rtl/core
rtl/core/cdq_pkg.sv
rtl/core/cdq_cell.sv
rtl/core/circular_deque_top.sv
rtl/core/cdq_checker.sv
dv/circular_deque_checker.sv
dv/circular_deque_top_tb.sv
